[src/omvn_pkg.sv]
`default_nettype none
package omvn_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 7;
    localparam int FILL_W   = 12;
    localparam int VFILL_W  = 7;
    localparam int ACC_W    = 64;
    localparam int G_W      = 33;
    localparam int J_W      = 5;
    localparam int TERM_W   = 42;
    localparam int SH_W     = 6;

    localparam logic [FILL_W-1:0] FILL_MAX  = 12'd4095;
    localparam logic [SH_W-1:0]   SHIFT_TOP = 6'd48;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_RSQ,
        ST_OUT_RD,
        ST_OUT_MUL,
        ST_OUT_RND,
        ST_OUT_HOLD
    } top_state_t;

    // Reciprocal square root unit states
    typedef enum logic [1:0] {
        RS_IDLE,
        RS_NORM,
        RS_SQRT,
        RS_DIV
    } rsq_state_t;

    // Tag that travels with one memory read into the accumulate datapath
    typedef struct packed {
        logic valid;
        logic k_ok;
        logic l_ok;
        logic diag;
    } mac_tag_t;

    // Result of the reciprocal square root unit
    typedef struct packed {
        logic           done;
        logic [G_W-1:0] g;
        logic [J_W-1:0] j;
    } rsq_res_t;

endpackage
`default_nettype wire

[src/omvn_ram.sv]
`default_nettype none
module omvn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/omvn_mac.sv]
`default_nettype none
module omvn_mac (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 clear,
    input  wire omvn_pkg::mac_tag_t                   tag,
    input  wire logic signed [omvn_pkg::VALUE_W-1:0]  ck,
    input  wire logic signed [omvn_pkg::VALUE_W-1:0]  cl,
    input  wire logic signed [omvn_pkg::VALUE_W-1:0]  s,
    output logic signed      [omvn_pkg::ACC_W-1:0]    acc,
    output logic                                      busy
);
    localparam int VW = omvn_pkg::VALUE_W;
    localparam int TW = omvn_pkg::TERM_W;
    localparam int AW = omvn_pkg::ACC_W;

    logic signed [VW-1:0] ck_z, cl_z;
    logic [VW-1:0]        mk, ml, ms;
    logic [63:0]          pp, tt;
    logic [39:0]          t40;
    logic [40:0]          t41;
    logic [AW:0]          sum;

    logic          v1_reg, v1_next;
    logic [VW-1:0] p_reg, p_next;
    logic [VW-1:0] ms_reg, ms_next;
    logic          neg_reg, neg_next;
    logic          diag_reg, diag_next;
    logic          v2_reg, v2_next;
    logic signed [TW-1:0] term_reg, term_next;
    logic signed [AW-1:0] acc_reg, acc_next;

    // Stage 1: zero missing coefficients, take magnitudes, first product
    always_comb begin
        ck_z      = tag.k_ok ? ck : '0;
        cl_z      = tag.l_ok ? cl : '0;
        mk        = ck_z[VW-1] ? VW'(-ck_z) : VW'(ck_z);
        ml        = cl_z[VW-1] ? VW'(-cl_z) : VW'(cl_z);
        ms        = s[VW-1] ? VW'(-s) : VW'(s);
        pp        = 64'(mk) * 64'(ml);
        v1_next   = tag.valid;
        p_next    = pp[62:31];
        ms_next   = ms;
        neg_next  = ck_z[VW-1] ^ cl_z[VW-1] ^ s[VW-1];
        diag_next = tag.diag;
    end

    // Stage 2: scale by overlap, double off the diagonal, apply sign
    always_comb begin
        tt      = 64'(p_reg) * 64'(ms_reg);
        t40     = tt[62:23];
        t41     = diag_reg ? {1'b0, t40} : {t40, 1'b0};
        v2_next = v1_reg;
        if (neg_reg) begin
            term_next = -$signed({1'b0, t41});
        end else begin
            term_next = $signed({1'b0, t41});
        end
    end

    // Stage 3: saturating accumulate
    always_comb begin
        sum      = {acc_reg[AW-1], acc_reg} + {{(AW+1-TW){term_reg[TW-1]}}, term_reg};
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (v2_reg) begin
            if (sum[AW] != sum[AW-1]) begin
                acc_next = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end else begin
                acc_next = sum[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            acc_reg <= acc_next;
        end
        p_reg    <= p_next;
        ms_reg   <= ms_next;
        neg_reg  <= neg_next;
        diag_reg <= diag_next;
        term_reg <= term_next;
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg;
endmodule
`default_nettype wire

[src/omvn_rsq.sv]
`default_nettype none
module omvn_rsq (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [omvn_pkg::ACC_W-1:0]   acc_in,
    output omvn_pkg::rsq_res_t                       res
);
    localparam int GW = omvn_pkg::G_W;
    localparam int JW = omvn_pkg::J_W;

    omvn_pkg::rsq_state_t state_reg, state_next;
    logic [63:0]   m_reg, m_next;
    logic [JW-1:0] j_reg, j_next;
    logic [63:0]   v_reg, v_next;
    logic [63:0]   root_reg, root_next;
    logic [63:0]   one_reg, one_next;
    logic [31:0]   div_reg, div_next;
    logic [31:0]   rem_reg, rem_next;
    logic [GW-1:0] q_reg, q_next;
    logic [5:0]    bit_reg, bit_next;
    logic          done_reg, done_next;

    logic [63:0] a_clamp, trial;
    logic [31:0] shifted;

    // Clamp sum to [1, 2^59], then normalize, root and divide one step a cycle
    always_comb begin
        state_next = state_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        one_next   = one_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        a_clamp    = 64'd1;
        trial      = root_reg + one_reg;
        shifted    = {rem_reg[30:0], bit_reg == 6'd62};

        if (acc_in > 64'sd0) begin
            a_clamp = (acc_in > (64'sd1 <<< 59)) ? (64'd1 << 59) : 64'(acc_in);
        end

        case (state_reg)
            omvn_pkg::RS_IDLE: begin
                if (start) begin
                    m_next     = a_clamp << 1;
                    j_next     = '0;
                    state_next = omvn_pkg::RS_NORM;
                end
            end
            omvn_pkg::RS_NORM: begin
                if (m_reg[63:60] == 4'd0) begin
                    m_next = m_reg << 2;
                    j_next = j_reg + JW'(1);
                end else begin
                    v_next     = m_reg;
                    root_next  = '0;
                    one_next   = 64'd1 << 60;
                    state_next = omvn_pkg::RS_SQRT;
                end
            end
            omvn_pkg::RS_SQRT: begin
                if (v_reg >= trial) begin
                    v_next    = v_reg - trial;
                    root_next = (root_reg >> 1) + one_reg;
                end else begin
                    root_next = root_reg >> 1;
                end
                one_next = one_reg >> 2;
                if (one_reg == 64'd1) begin
                    div_next   = root_next[31:0];
                    rem_next   = '0;
                    q_next     = '0;
                    bit_next   = 6'd62;
                    state_next = omvn_pkg::RS_DIV;
                end
            end
            omvn_pkg::RS_DIV: begin
                if (shifted >= div_reg) begin
                    rem_next = shifted - div_reg;
                    q_next   = {q_reg[GW-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    q_next   = {q_reg[GW-2:0], 1'b0};
                end
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0) begin
                    done_next  = 1'b1;
                    state_next = omvn_pkg::RS_IDLE;
                end
            end
            default: begin
                state_next = omvn_pkg::RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= omvn_pkg::RS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        m_reg    <= m_next;
        j_reg    <= j_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        one_reg  <= one_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        bit_reg  <= bit_next;
    end

    assign res.done = done_reg;
    assign res.g    = q_reg;
    assign res.j    = j_reg;
endmodule
`default_nettype wire

[src/overlap_metric_vector_normalizer.sv]
`default_nettype none
// Overlap-metric vector normalizer.
// Input channel (s_*): opcode 0 items load the packed lower triangle of the
// overlap matrix row by row; s_last closes the load. Opcode 1 items load one
// coefficient vector; s_last on a coefficient starts the computation.
// Result channel (m_*): one transfer per coefficient, clamped basis_count of them,
// m_last_out on the final one. Configuration: cfg_wr_en writes basis_count.
// Items load while the block is idle. After the last coefficient, if the
// overlap count matches, the block runs n(n+1)/2 multiply-accumulates at one
// per cycle through a three-stage datapath fed by the overlap and vector
// memories, then a reciprocal square root (normalize 2 bits, root 1 bit and
// divide 1 bit per cycle), then emits each coefficient through read, multiply,
// round and hold states, holding until m_ready; otherwise it emits the
// coefficients unnormalized. s_ready is low from the last coefficient until
// the last result transfers. When m_ready is low the result register holds.
// Reset clears fill counts, the accumulator and the handshake; basis_count
// returns to 1. No clearing pass is needed.
module overlap_metric_vector_normalizer #(
    parameter int MAX_BASIS = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [omvn_pkg::CFG_W-1:0]            cfg_wr_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_opcode,
    input  wire logic signed [omvn_pkg::VALUE_W-1:0]   s_value,
    input  wire logic                                  s_last,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [omvn_pkg::VALUE_W-1:0]        m_coef_out,
    output logic                                       m_normalized,
    output logic                                       m_last_out
);
    localparam int VW        = omvn_pkg::VALUE_W;
    localparam int CW        = omvn_pkg::CFG_W;
    localparam int FW        = omvn_pkg::FILL_W;
    localparam int NW        = omvn_pkg::VFILL_W;
    localparam int OVL_DEPTH = MAX_BASIS * (MAX_BASIS + 1) / 2;
    localparam int KW        = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int IW        = (OVL_DEPTH > 1) ? $clog2(OVL_DEPTH) : 1;

    omvn_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] basis_reg, basis_next;
    logic [FW-1:0] ofill_reg, ofill_next;
    logic          oclosed_reg, oclosed_next;
    logic [NW-1:0] vfill_reg, vfill_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] l_reg, l_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          norm_reg, norm_next;
    omvn_pkg::mac_tag_t tag_reg, tag_next;
    logic          mvalid_reg, mvalid_next;
    logic [VW-1:0] coef_reg, coef_next;
    logic          last_reg, last_next;
    logic [64:0]   prod_reg, prod_next;
    logic signed [VW-1:0] cz_reg, cz_next;

    logic [CW-1:0] n_eff;
    logic [13:0]   tri_n;
    logic          count_ok;
    logic          in_xfer;
    logic [FW-1:0] obase;
    logic          ovl_we, vec_we;
    logic [IW-1:0] ovl_waddr;
    logic          acc_clear, rsq_start;
    logic          k_is_last, k_ok;
    logic [VW-1:0] cmag;
    logic [omvn_pkg::SH_W-1:0] sh;
    logic [65:0]   rnd;
    logic [65:0]   rmag;

    logic signed [VW-1:0] vec_a_rdata, vec_b_rdata, ovl_rdata;
    logic signed [omvn_pkg::ACC_W-1:0] acc;
    logic               mac_busy;
    omvn_pkg::rsq_res_t rsq_res;

    // Effective order and expected overlap count
    always_comb begin
        if (basis_reg == '0) begin
            n_eff = CW'(1);
        end else if (basis_reg > CW'(MAX_BASIS)) begin
            n_eff = CW'(MAX_BASIS);
        end else begin
            n_eff = basis_reg;
        end
        tri_n    = (14'(n_eff) * (14'(n_eff) + 14'd1)) >> 1;
        count_ok = (14'(ofill_reg) == tri_n);
    end

    assign in_xfer   = s_valid && s_ready;
    assign obase     = oclosed_reg ? '0 : ofill_reg;
    assign ovl_we    = in_xfer && !s_opcode && (obase < FW'(OVL_DEPTH));
    assign ovl_waddr = obase[IW-1:0];
    assign vec_we    = in_xfer && s_opcode && (vfill_reg < NW'(MAX_BASIS));
    assign k_is_last = (NW'(k_reg) == NW'(n_eff) - NW'(1));
    assign k_ok      = (NW'(k_reg) < vfill_reg);

    // Sequencer: load, accumulate, root, emit (straight to emit when the overlap count is off)
    always_comb begin
        state_next   = state_reg;
        basis_next   = cfg_wr_en ? cfg_wr_data : basis_reg;
        ofill_next   = ofill_reg;
        oclosed_next = oclosed_reg;
        vfill_next   = vfill_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        idx_next     = idx_reg;
        norm_next    = norm_reg;
        tag_next     = '0;
        mvalid_next  = mvalid_reg;
        coef_next    = coef_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        cz_next      = cz_reg;
        s_ready      = 1'b0;
        acc_clear    = 1'b0;
        rsq_start    = 1'b0;
        cmag         = '0;
        sh           = omvn_pkg::SHIFT_TOP - omvn_pkg::SH_W'(rsq_res.j);
        rnd          = {1'b0, prod_reg} + (66'd1 << (sh - omvn_pkg::SH_W'(1)));
        rmag         = rnd >> sh;

        case (state_reg)
            omvn_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (in_xfer) begin
                    if (!s_opcode) begin
                        ofill_next   = (obase < omvn_pkg::FILL_MAX) ? obase + FW'(1) : obase;
                        oclosed_next = s_last;
                    end else begin
                        if (vec_we) begin
                            vfill_next = vfill_reg + NW'(1);
                        end
                        if (s_last) begin
                            k_next   = '0;
                            l_next   = '0;
                            idx_next = '0;
                            if (count_ok) begin
                                state_next = omvn_pkg::ST_ACC;
                            end else begin
                                norm_next  = 1'b0;
                                state_next = omvn_pkg::ST_OUT_RD;
                            end
                        end
                    end
                end
            end
            omvn_pkg::ST_ACC: begin
                // Issue one read triple per cycle
                tag_next.valid = 1'b1;
                tag_next.k_ok  = k_ok;
                tag_next.l_ok  = (NW'(l_reg) < vfill_reg);
                tag_next.diag  = (l_reg == k_reg);
                idx_next       = idx_reg + IW'(1);
                if (l_reg == k_reg) begin
                    l_next = '0;
                    k_next = k_reg + KW'(1);
                    if (k_is_last) begin
                        state_next = omvn_pkg::ST_DRAIN;
                    end
                end else begin
                    l_next = l_reg + KW'(1);
                end
            end
            omvn_pkg::ST_DRAIN: begin
                if (!tag_reg.valid && !mac_busy) begin
                    rsq_start  = 1'b1;
                    state_next = omvn_pkg::ST_RSQ;
                end
            end
            omvn_pkg::ST_RSQ: begin
                if (rsq_res.done) begin
                    k_next     = '0;
                    norm_next  = 1'b1;
                    state_next = omvn_pkg::ST_OUT_RD;
                end
            end
            omvn_pkg::ST_OUT_RD: begin
                state_next = omvn_pkg::ST_OUT_MUL;
            end
            omvn_pkg::ST_OUT_MUL: begin
                cz_next    = k_ok ? vec_a_rdata : '0;
                cmag       = cz_next[VW-1] ? VW'(-cz_next) : VW'(cz_next);
                prod_next  = 65'(cmag) * 65'(rsq_res.g);
                state_next = omvn_pkg::ST_OUT_RND;
            end
            omvn_pkg::ST_OUT_RND: begin
                if (!norm_reg) begin
                    coef_next = cz_reg;
                end else if (!cz_reg[VW-1]) begin
                    coef_next = (rmag > 66'h7FFF_FFFF) ? 32'h7FFF_FFFF : rmag[VW-1:0];
                end else if (rmag > 66'h8000_0000) begin
                    coef_next = 32'h8000_0000;
                end else begin
                    coef_next = VW'(-rmag[VW-1:0]);
                end
                last_next   = k_is_last;
                mvalid_next = 1'b1;
                state_next  = omvn_pkg::ST_OUT_HOLD;
            end
            omvn_pkg::ST_OUT_HOLD: begin
                if (m_ready) begin
                    mvalid_next = 1'b0;
                    if (last_reg) begin
                        vfill_next = '0;
                        acc_clear  = 1'b1;
                        state_next = omvn_pkg::ST_IDLE;
                    end else begin
                        k_next     = k_reg + KW'(1);
                        state_next = omvn_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = omvn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= omvn_pkg::ST_IDLE;
            basis_reg   <= CW'(1);
            ofill_reg   <= '0;
            oclosed_reg <= 1'b0;
            vfill_reg   <= '0;
            tag_reg     <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            basis_reg   <= basis_next;
            ofill_reg   <= ofill_next;
            oclosed_reg <= oclosed_next;
            vfill_reg   <= vfill_next;
            tag_reg     <= tag_next;
            mvalid_reg  <= mvalid_next;
        end
        k_reg    <= k_next;
        l_reg    <= l_next;
        idx_reg  <= idx_next;
        norm_reg <= norm_next;
        coef_reg <= coef_next;
        last_reg <= last_next;
        prod_reg <= prod_next;
        cz_reg   <= cz_next;
    end

    // Overlap store
    omvn_ram #(.WIDTH(VW), .DEPTH(OVL_DEPTH)) u_ovl_ram (
        .aclk  (aclk),
        .we    (ovl_we),
        .waddr (ovl_waddr),
        .wdata (s_value),
        .raddr (idx_reg),
        .rdata (ovl_rdata)
    );

    // Vector store, two copies for the row and column reads
    omvn_ram #(.WIDTH(VW), .DEPTH(MAX_BASIS)) u_vec_a_ram (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (vfill_reg[KW-1:0]),
        .wdata (s_value),
        .raddr (k_reg),
        .rdata (vec_a_rdata)
    );

    omvn_ram #(.WIDTH(VW), .DEPTH(MAX_BASIS)) u_vec_b_ram (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (vfill_reg[KW-1:0]),
        .wdata (s_value),
        .raddr (l_reg),
        .rdata (vec_b_rdata)
    );

    omvn_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (acc_clear),
        .tag     (tag_reg),
        .ck      (vec_a_rdata),
        .cl      (vec_b_rdata),
        .s       (ovl_rdata),
        .acc     (acc),
        .busy    (mac_busy)
    );

    omvn_rsq u_rsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rsq_start),
        .acc_in  (acc),
        .res     (rsq_res)
    );

    assign m_valid      = mvalid_reg;
    assign m_coef_out   = coef_reg;
    assign m_normalized = norm_reg;
    assign m_last_out   = last_reg;

`ifndef ASSERT_OFF
    // Input and output never open together
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("s_ready high while a result is pending");

    // Final result transfer returns the block to loading
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> s_ready)
        else $error("block not ready after last result");

    // A result appears only after the rounding step
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == omvn_pkg::ST_OUT_RND))
        else $error("result valid without rounding step");

    // Root unit is started only with the datapath drained
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        rsq_start |-> (!mac_busy && !tag_reg.valid))
        else $error("root started with accumulation in flight");
`endif
endmodule
`default_nettype wire
